// File: rtl/core/cholesky_decomposition_macros.svh
// assertion macros shared by the cholesky factor rtl
`ifndef CHOLESKY_DECOMPOSITION_MACROS_SVH
`define CHOLESKY_DECOMPOSITION_MACROS_SVH

// same-cycle implication, clocked on i_clk, quiet in reset
`define CHD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, quiet in reset
`define CHD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/chd_pkg.sv
// shared constants for the cholesky factor block
package chd_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int Q_W           = 32;
    localparam int SIZE_W        = 4;
    localparam int IDX_OUT_W     = 3;
    localparam int WIDE_W        = 64;
    localparam int FRAC_W        = 16;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 64;
    localparam int STEP_W        = 7;

    localparam logic signed [WIDE_W-1:0] WIDE_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [Q_W-1:0]    Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]    Q_MIN      = 32'sh8000_0000;
    localparam logic [SIZE_W-1:0]        SIZE_RESET = 4'd8;

endpackage

// File: rtl/core/chd_in_if.sv
// input channel: one lower-triangle word of a
interface chd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [chd_pkg::Q_W-1:0]      element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// File: rtl/core/chd_cfg_if.sv
// configuration channel: matrix order write
interface chd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [chd_pkg::SIZE_W-1:0]          matrix_size;

    modport source (output valid, output matrix_size, input ready);
    modport sink   (input valid, input matrix_size, output ready);
endinterface

// File: rtl/core/chd_out_if.sv
// output channel: one word of the factor with its marks
interface chd_out_if;
    logic                                valid;
    logic                                ready;
    logic [chd_pkg::IDX_OUT_W-1:0]       row_index;
    logic [chd_pkg::IDX_OUT_W-1:0]       col_index;
    logic signed [chd_pkg::Q_W-1:0]      l_value;
    logic                                not_pos_definite;
    logic                                last_result;

    modport source (output valid, output row_index, output col_index, output l_value,
                    output not_pos_definite, output last_result, input ready);
    modport sink   (input valid, input row_index, input col_index, input l_value,
                    input not_pos_definite, input last_result, output ready);
endinterface

// File: rtl/core/chd_ram.sv
// generic single-write, single-read ram with registered read data
module chd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: rtl/core/cholesky_decomposition.sv
// cholesky factor engine: loads the lower triangle of a, factors in place, emits l
//
//  channel   dir   handshake      payload
//  i_cfg     in    valid/ready    matrix_size (order n, 0 acts as 1, clamped to MAX_ORDER)
//  i_in      in    valid/ready    element_value (q16.16, row-major lower triangle)
//  o_out     out   valid/ready    row_index, col_index, l_value, not_pos_definite, last_result
//
// loading takes one word a cycle while i_cfg is not valid; the word that completes the triangle starts the factor
// the factor runs on one 32x32 multiplier, one 64-bit radix-4 root unit and one
// bit-serial divider
// each word of l is then read, loaded and held on o_out until taken; i_in is not ready meanwhile
// synchronous active-low reset clears control state; the store holds no reset value
`include "cholesky_decomposition_macros.svh"

module cholesky_decomposition #(
    parameter int MAX_ORDER = chd_pkg::MAX_ORDER_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chd_cfg_if.sink   i_cfg,
    chd_in_if.sink    i_in,
    chd_out_if.source o_out
);

    import chd_pkg::*;

    localparam int DEPTH  = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 2 * ORD_W + 1;

    typedef enum logic [14:0] {
        S_LOAD     = 15'b000000000000001,
        S_DOT_RA   = 15'b000000000000010,
        S_DOT_RB   = 15'b000000000000100,
        S_MUL      = 15'b000000000001000,
        S_ACC      = 15'b000000000010000,
        S_RD_A     = 15'b000000000100000,
        S_DIFF     = 15'b000000001000000,
        S_SQRT     = 15'b000000010000000,
        S_SQ_END   = 15'b000000100000000,
        S_DIV      = 15'b000001000000000,
        S_DIV_END  = 15'b000010000000000,
        S_WR       = 15'b000100000000000,
        S_OUT_RD   = 15'b001000000000000,
        S_OUT_LD   = 15'b010000000000000,
        S_OUT_WAIT = 15'b100000000000000
    } t_state;

    // position of entry (r, c) in the packed lower triangle
    function automatic logic [TOT_W-1:0] tri_pos(input logic [ORD_W-1:0] r,
                                                 input logic [ORD_W-1:0] c);
        logic [POS_W-1:0] t;
        t = POS_W'(r) * (POS_W'(r) + POS_W'(1));
        return TOT_W'(t >> 1) + TOT_W'(c);
    endfunction

    t_state                    r_state, n_state;
    logic [SIZE_W-1:0]         r_size;
    logic [TOT_W-1:0]          r_load_cnt;
    logic                      r_err;
    logic [ORD_W-1:0]          r_k, r_i, r_s;
    logic signed [WIDE_W-1:0]  r_acc;
    logic signed [Q_W-1:0]     r_opa;
    logic signed [WIDE_W-1:0]  r_prod;
    logic signed [Q_W-1:0]     r_piv;
    logic signed [Q_W-1:0]     r_val;
    logic [WIDE_W-1:0]         r_x, r_r, r_bit;
    logic [WIDE_W-1:0]         r_q;
    logic [Q_W-2:0]            r_rem;
    logic                      r_neg;
    logic [STEP_W-1:0]         r_step;
    logic [TOT_W-1:0]          r_emit;
    logic [ORD_W-1:0]          r_orow, r_ocol;
    logic                      r_ovalid;

    logic [ORD_W-1:0]          w_n;
    logic [TOT_W-1:0]          w_total;
    logic [TOT_W-1:0]          w_load_pos;
    logic                      w_in_acc, w_cfg_acc, w_out_acc;
    logic                      w_we;
    logic [ADDR_W-1:0]         w_waddr, w_raddr;
    logic [Q_W-1:0]            w_wdata, w_rdata;
    logic signed [WIDE_W-1:0]  w_d, w_trunc, w_num, w_dcl;
    logic [WIDE_W-1:0]         w_rb;
    logic [Q_W-1:0]            w_t;
    logic                      w_last_emit;
    logic                      w_last_shown;

    // order in use and triangle size
    always_comb begin
        if (32'(r_size) > MAX_ORDER) begin
            w_n = ORD_W'(MAX_ORDER);
        end else if (r_size == '0) begin
            w_n = ORD_W'(1);
        end else begin
            w_n = ORD_W'(r_size);
        end
        w_total = tri_pos(w_n - ORD_W'(1), w_n - ORD_W'(1)) + TOT_W'(1);
    end

    // handshakes: order writes only while loading, and they take the cycle
    assign i_cfg.ready  = (r_state == S_LOAD);
    assign i_in.ready   = (r_state == S_LOAD) && !i_cfg.valid;
    assign w_cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign w_in_acc     = i_in.valid && i_in.ready;
    assign w_out_acc    = o_out.valid && o_out.ready;
    assign w_load_pos   = (r_load_cnt >= w_total) ? '0 : r_load_cnt;
    assign w_last_emit  = (r_emit + TOT_W'(1) == w_total);
    assign w_last_shown = o_out.valid && o_out.last_result;

    // store ports
    chd_ram #(
        .WIDTH (Q_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_wdata),
        .i_rd_addr (w_raddr),
        .o_rd_data (w_rdata)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = ADDR_W'(w_load_pos);
        w_wdata = i_in.element_value;
        if (w_in_acc && !w_cfg_acc) begin
            w_we = 1'b1;
        end else if (r_state == S_WR) begin
            w_we    = 1'b1;
            w_waddr = ADDR_W'(tri_pos(r_i, r_k));
            w_wdata = r_val;
        end
    end

    always_comb begin
        unique case (r_state)
            S_DOT_RA: w_raddr = ADDR_W'(tri_pos(r_i, r_s));
            S_DOT_RB: w_raddr = ADDR_W'(tri_pos(r_k, r_s));
            S_RD_A:   w_raddr = ADDR_W'(tri_pos(r_i, r_k));
            default:  w_raddr = ADDR_W'(r_emit);
        endcase
    end

    // arithmetic helpers: truncated product, pivot and numerator, root trial, divider trial
    always_comb begin
        w_trunc = (r_prod >>> FRAC_W) +
                  ((r_prod[WIDE_W-1] && (|r_prod[FRAC_W-1:0])) ? 64'sd1 : 64'sd0);
        w_d     = WIDE_W'($signed(w_rdata)) - r_acc;
        w_dcl   = (w_d > WIDE_LIMIT) ? WIDE_LIMIT : w_d;
        if (w_d > WIDE_LIMIT) begin
            w_num = WIDE_LIMIT;
        end else if (w_d < -WIDE_LIMIT) begin
            w_num = -WIDE_LIMIT;
        end else begin
            w_num = w_d;
        end
        w_rb = r_r + r_bit;
        w_t  = {r_rem, r_q[WIDE_W-1]};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && !w_cfg_acc && (w_load_pos + TOT_W'(1) == w_total)) begin
                    n_state = S_RD_A;
                end
            end
            S_DOT_RA: n_state = S_DOT_RB;
            S_DOT_RB: n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = (r_s + ORD_W'(1) < r_k) ? S_DOT_RA : S_RD_A;
            S_RD_A:   n_state = S_DIFF;
            S_DIFF: begin
                if (r_i == r_k) begin
                    n_state = (w_d <= 64'sd0) ? S_WR : S_SQRT;
                end else begin
                    n_state = (r_piv <= 32'sd0) ? S_WR : S_DIV;
                end
            end
            S_SQRT:    n_state = (r_step == '0) ? S_SQ_END : S_SQRT;
            S_SQ_END:  n_state = S_WR;
            S_DIV:     n_state = (r_step == '0) ? S_DIV_END : S_DIV;
            S_DIV_END: n_state = S_WR;
            S_WR: begin
                if (r_i + ORD_W'(1) < w_n) begin
                    n_state = (r_k != '0) ? S_DOT_RA : S_RD_A;
                end else if (r_k + ORD_W'(1) < w_n) begin
                    n_state = S_DOT_RA;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (w_out_acc) begin
                    n_state = o_out.last_result ? S_LOAD : S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_size     <= SIZE_RESET;
            r_load_cnt <= '0;
            r_err      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                r_size     <= i_cfg.matrix_size;
                r_load_cnt <= '0;
            end else if (w_in_acc) begin
                if (w_load_pos + TOT_W'(1) == w_total) begin
                    r_load_cnt <= '0;
                    r_err      <= 1'b0;
                end else begin
                    r_load_cnt <= w_load_pos + TOT_W'(1);
                end
            end
            if (r_state == S_DIFF && r_i == r_k && w_d <= 64'sd0) begin
                r_err <= 1'b1;
            end
            if (r_state == S_OUT_LD) begin
                r_ovalid <= 1'b1;
            end else if (w_out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                r_k   <= '0;
                r_i   <= '0;
                r_s   <= '0;
                r_acc <= '0;
            end
            S_DOT_RA: ;
            S_DOT_RB: r_opa  <= w_rdata;
            S_MUL:    r_prod <= WIDE_W'(r_opa) * WIDE_W'($signed(w_rdata));
            S_ACC: begin
                r_acc <= r_acc + w_trunc;
                r_s   <= r_s + ORD_W'(1);
            end
            S_RD_A: ;
            S_DIFF: begin
                r_val <= '0;
                r_r   <= '0;
                r_bit <= 64'd1 << 62;
                r_x   <= 64'(w_dcl) << FRAC_W;
                r_rem <= '0;
                r_neg <= w_num[WIDE_W-1];
                r_q   <= (w_num[WIDE_W-1] ? 64'(-w_num) : 64'(w_num)) << FRAC_W;
                r_step <= (r_i == r_k) ? STEP_W'(SQRT_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
            end
            S_SQRT: begin
                if (r_x >= w_rb) begin
                    r_x <= r_x - w_rb;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step - STEP_W'(1);
            end
            S_SQ_END: begin
                r_val <= (r_r[WIDE_W-1:Q_W-1] != '0) ? Q_MAX : r_r[Q_W-1:0];
            end
            S_DIV: begin
                if (w_t >= {1'b0, r_piv[Q_W-2:0]}) begin
                    r_rem <= (Q_W-1)'(w_t - {1'b0, r_piv[Q_W-2:0]});
                    r_q   <= {r_q[WIDE_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_t[Q_W-2:0];
                    r_q   <= {r_q[WIDE_W-2:0], 1'b0};
                end
                r_step <= r_step - STEP_W'(1);
            end
            S_DIV_END: begin
                if (r_neg) begin
                    r_val <= (r_q > 64'h8000_0000) ? Q_MIN : Q_W'(-r_q);
                end else begin
                    r_val <= (r_q > 64'h7FFF_FFFF) ? Q_MAX : r_q[Q_W-1:0];
                end
            end
            S_WR: begin
                if (r_i == r_k) begin
                    r_piv <= r_val;
                end
                r_s   <= '0;
                r_acc <= '0;
                if (r_i + ORD_W'(1) < w_n) begin
                    r_i <= r_i + ORD_W'(1);
                end else if (r_k + ORD_W'(1) < w_n) begin
                    r_k <= r_k + ORD_W'(1);
                    r_i <= r_k + ORD_W'(1);
                end
                r_emit <= '0;
                r_orow <= '0;
                r_ocol <= '0;
            end
            S_OUT_RD: ;
            S_OUT_LD: begin
                o_out.row_index        <= IDX_OUT_W'(r_orow);
                o_out.col_index        <= IDX_OUT_W'(r_ocol);
                o_out.l_value          <= w_rdata;
                o_out.not_pos_definite <= r_err;
                o_out.last_result      <= w_last_emit;
            end
            S_OUT_WAIT: begin
                if (w_out_acc) begin
                    r_emit <= r_emit + TOT_W'(1);
                    if (r_ocol == r_orow) begin
                        r_orow <= r_orow + ORD_W'(1);
                        r_ocol <= '0;
                    end else begin
                        r_ocol <= r_ocol + ORD_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid = r_ovalid;

    // checks on the sequencer and output word
    `CHD_ASSERT_IMP(a_out_in_wait, o_out.valid, r_state == S_OUT_WAIT, "word outside wait")
    `CHD_ASSERT_IMP(a_col_le_row, o_out.valid, o_out.col_index <= o_out.row_index, "col above row")
    `CHD_ASSERT_IMP(a_last_diag, w_last_shown, o_out.row_index == o_out.col_index, "last off diag")
    `CHD_ASSERT_IMP(a_root_pos, r_state == S_WR && r_i == r_k, !r_val[Q_W-1], "negative pivot")
    `CHD_ASSERT_NXT(a_back_to_load, w_out_acc && o_out.last_result, r_state == S_LOAD, "no reload")

endmodule

// File: dv/cholesky_factor_checker.sv
// checker for the cholesky factor engine: tracks loads, predicts each word of l, compares
`timescale 1ns / 1ps

module cholesky_factor_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    chd_cfg_if   cfg_ch,
    chd_in_if    in_ch,
    chd_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_words_seen
);
    import chd_pkg::*;

    localparam int STORE_DEPTH = MAX_ORDER_DEF * (MAX_ORDER_DEF + 1) / 2;
    localparam longint Q_ONE   = 64'sd65536;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]    row;
        logic [IDX_OUT_W-1:0]    col;
        logic signed [Q_W-1:0]   value;
        logic                    npd;
        logic                    last;
    } t_l_word;

    t_l_word               factor_words_q[$];
    logic signed [Q_W-1:0] tri_a [STORE_DEPTH];
    int                    load_pos;
    logic [SIZE_W-1:0]     order_reg;
    bit                    pivot_fail;

    function automatic int tri_pos(int r, int c);
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic int order_eff();
        if (order_reg < 1) return 1;
        if (order_reg > MAX_ORDER_DEF) return MAX_ORDER_DEF;
        return int'(order_reg);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[Q_W-1:0];
    endfunction

    function automatic longint clamp_wide(longint v);
        if (v > longint'(WIDE_LIMIT)) return longint'(WIDE_LIMIT);
        if (v < -longint'(WIDE_LIMIT)) return -longint'(WIDE_LIMIT);
        return v;
    endfunction

    // integer square root, digit by digit
    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // sum of truncated q16.16 products over the first len columns of rows a and b
    function automatic longint row_dot(int a, int b, int len);
        longint acc;
        acc = 0;
        for (int s = 0; s < len; s++)
            acc += (longint'(tri_a[tri_pos(a, s)]) * longint'(tri_a[tri_pos(b, s)])) / Q_ONE;
        return acc;
    endfunction

    // in-place factor of the loaded triangle
    task automatic factor_triangle(int n);
        longint                d;
        longint                num;
        logic signed [Q_W-1:0] piv;
        pivot_fail = 1'b0;
        for (int k = 0; k < n; k++) begin
            d   = longint'(tri_a[tri_pos(k, k)]) - row_dot(k, k, k);
            piv = '0;
            if (d <= 0) begin
                pivot_fail = 1'b1;
            end else begin
                if (d > longint'(WIDE_LIMIT)) d = longint'(WIDE_LIMIT);
                piv = sat_q(longint'(int_root(longint'(d) << 16)));
            end
            tri_a[tri_pos(k, k)] = piv;
            for (int i = k + 1; i < n; i++) begin
                if (piv > 0) begin
                    num = clamp_wide(longint'(tri_a[tri_pos(i, k)]) - row_dot(i, k, k));
                    tri_a[tri_pos(i, k)] = sat_q((num * Q_ONE) / longint'(piv));
                end else begin
                    tri_a[tri_pos(i, k)] = '0;
                end
            end
        end
    endtask

    // store one word; the word that completes the triangle yields the whole factor
    task automatic take_element(logic signed [Q_W-1:0] v);
        int      n;
        int      total;
        int      cnt;
        t_l_word w;
        n     = order_eff();
        total = n * (n + 1) / 2;
        if (load_pos >= total) load_pos = 0;
        tri_a[load_pos] = v;
        load_pos++;
        if (load_pos < total) return;
        load_pos = 0;
        factor_triangle(n);
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j <= i; j++) begin
                w.row   = i[IDX_OUT_W-1:0];
                w.col   = j[IDX_OUT_W-1:0];
                w.value = tri_a[tri_pos(i, j)];
                w.npd   = pivot_fail;
                w.last  = (cnt + 1 == total);
                factor_words_q.push_back(w);
                cnt++;
            end
        end
    endtask

    task automatic report_mismatch(string what, t_l_word exp_w, t_l_word got_w);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t mismatch %s: expected r%0d c%0d v%h npd%0b last%0b,",
                     $realtime, what, exp_w.row, exp_w.col, exp_w.value, exp_w.npd,
                     exp_w.last, " got r%0d c%0d v%h npd%0b last%0b",
                     got_w.row, got_w.col, got_w.value, got_w.npd, got_w.last);
    endtask

    // watch the three channels
    always @(posedge i_clk) begin : watch
        t_l_word got_w;
        t_l_word exp_w;
        if (!i_rst_n) begin
            load_pos   = 0;
            order_reg  = SIZE_RESET;
            pivot_fail = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_w.row   = out_ch.row_index;
                got_w.col   = out_ch.col_index;
                got_w.value = out_ch.l_value;
                got_w.npd   = out_ch.not_pos_definite;
                got_w.last  = out_ch.last_result;
                o_words_seen++;
                if (factor_words_q.size() == 0) begin
                    report_mismatch("unexpected word", '0, got_w);
                end else begin
                    exp_w = factor_words_q.pop_front();
                    if (got_w != exp_w) report_mismatch("word", exp_w, got_w);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                order_reg = cfg_ch.matrix_size;
                load_pos  = 0;
            end
            if (in_ch.valid && in_ch.ready) take_element(in_ch.element_value);
        end
        o_pending = factor_words_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_words_seen = 0;
        o_pending    = 0;
        load_pos     = 0;
        order_reg    = SIZE_RESET;
        for (int i = 0; i < STORE_DEPTH; i++) tri_a[i] = '0;
    end

endmodule

// File: dv/tb_cholesky_decomposition.sv
// testbench top for the cholesky factor engine: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_cholesky_decomposition;
    import chd_pkg::*;

    localparam int STALL_LIMIT = 40000;
    localparam int ITEM_GOAL   = 110;
    localparam int DRAIN_WAIT  = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   words_seen;
    int   items_sent;
    int   matrices_sent;
    int   order_now;
    int   quiet_cycles;
    bit   steady;

    chd_cfg_if cfg_ch();
    chd_in_if  in_ch();
    chd_out_if out_ch();

    cholesky_decomposition dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cholesky_factor_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_ch       (cfg_ch),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_words_seen (words_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        out_ch.ready = steady || ($urandom_range(99) >= 29);
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int clamp_order(int v);
        if (v < 1) return 1;
        if (v > MAX_ORDER_DEF) return MAX_ORDER_DEF;
        return v;
    endfunction

    // one word into the load port, called at a falling edge
    task automatic send_word(logic signed [Q_W-1:0] v);
        while (!steady && $urandom_range(99) < 29) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.element_value = v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // order write once every factor word has drained
    task automatic write_order(logic [SIZE_W-1:0] sz);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        cfg_ch.valid       = 1'b1;
        cfg_ch.matrix_size = sz;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        order_now    = clamp_order(int'(sz));
    endtask

    // diagonally dominant matrix, so every pivot is positive
    task automatic send_dominant(int n);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j <= i; j++) begin
                if (i == j)
                    send_word(n * (1 << 19) + int'($urandom_range(1 << 24, 1)));
                else
                    send_word(int'($urandom_range(1 << 20, 0)) - (1 << 19));
            end
        end
        matrices_sent++;
    endtask

    // arbitrary words, mostly failing pivots and saturation
    task automatic send_noise(int n);
        for (int i = 0; i < n * (n + 1) / 2; i++) begin
            case ($urandom_range(3))
                0: send_word(Q_MAX);
                1: send_word(Q_MIN);
                default: send_word($urandom);
            endcase
        end
        matrices_sent++;
    endtask

    initial begin
        int kind;
        int part;
        i_rst_n            = 1'b0;
        steady             = 1'b0;
        quiet_cycles       = 0;
        items_sent         = 0;
        matrices_sent      = 0;
        order_now          = MAX_ORDER_DEF;
        cfg_ch.valid       = 1'b0;
        cfg_ch.matrix_size = SIZE_RESET;
        in_ch.valid        = 1'b0;
        in_ch.element_value = '0;
        out_ch.ready       = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // order one: extremes, zero and negative pivots
        write_order(4'd1);
        send_word(Q_MAX);
        send_word(Q_MIN);
        send_word(32'sd0);
        send_word(32'sd65536);
        send_word(-32'sd65536);
        // order zero acts as one
        write_order(4'd0);
        send_word(32'sd4);
        // order two: zero first pivot, negative second pivot, saturated column
        write_order(4'd2);
        send_word(32'sd0);
        send_word(32'sd131072);
        send_word(32'sd65536);
        send_word(32'sd65536);
        send_word(32'sd131072);
        send_word(32'sd65536);
        send_word(32'sd1);
        send_word(Q_MAX);
        send_word(Q_MAX);
        matrices_sent += 9;

        // order above the maximum acts as the maximum; load and drain without idling
        write_order(4'd15);
        steady = 1'b1;
        send_dominant(order_now);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        steady = 1'b0;

        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(99) < 40) begin
                part = $urandom_range(99);
                if (part < 70)      write_order(4'($urandom_range(4, 1)));
                else if (part < 85) write_order($urandom_range(1) ? 4'd8 : 4'd15);
                else                write_order(4'($urandom_range(7, 0)));
            end
            kind = $urandom_range(99);
            if (kind < 70) begin
                send_dominant(order_now);
            end else if (kind < 85 || order_now == 1) begin
                send_noise(order_now);
            end else begin
                // partial load dropped by an order write
                part = $urandom_range(order_now * (order_now + 1) / 2 - 1, 1);
                repeat (part) send_word($urandom);
                write_order(4'(order_now));
            end
        end
        in_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("loaded %0d words over %0d matrices of order 1 to 8, checked %0d words of l",
                 items_sent, matrices_sent, words_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
